/* rtl/core/sdp_pkg.sv */
// shared types, widths and helpers for the seed hit chaining block
package sdp_pkg;

    localparam int MAX_HITS  = 1024;
    localparam int IDX_W     = $clog2(MAX_HITS);
    localparam int CNT_W     = $clog2(MAX_HITS + 1);
    localparam int POS_W     = 32;
    localparam int LEN_W     = 16;
    localparam int SCORE_W   = 48;
    localparam int OUT_IDX_W = 10;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SUM_W     = SCORE_W + 2;
    localparam int IN_W      = 2 * POS_W + LEN_W;
    localparam int OUT_W     = 72;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic             start_set;
        logic [POS_W-1:0] hit_x;
        logic [POS_W-1:0] hit_y;
        logic [LEN_W-1:0] hit_length;
    } hit_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   x;
    } ram_word_t;

    localparam int RAM_W = $bits(ram_word_t);

    typedef struct packed {
        logic [SCORE_W-1:0]   chain_score;
        logic [OUT_IDX_W-1:0] pred_index;
        logic                 has_pred;
        logic [OUT_IDX_W-1:0] hit_index;
        logic                 overflow;
    } result_t;

    function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] v);
        logic [IDX_W+OUT_IDX_W-1:0] t;
        t = {{OUT_IDX_W{1'b0}}, v};
        return t[OUT_IDX_W-1:0];
    endfunction

endpackage

/* rtl/core/sdp_ram.sv */
// generic simple dual port ram with registered read
module sdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sdp_front.sv */
// input side: accepts hits and queues them for the chaining engine
module sdp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [sdp_pkg::IN_W-1:0] s_axis_tdata,  // hit_x, hit_y, hit_length
    input  logic                   s_axis_tuser,  // start_set
    output logic                   q_valid,
    input  logic                   q_pop,
    output sdp_pkg::hit_t          q_item
);
    import sdp_pkg::*;

    hit_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;
    hit_t              in_item;

    always_comb
    begin
        in_item.start_set  = s_axis_tuser;
        in_item.hit_x      = s_axis_tdata[POS_W-1:0];
        in_item.hit_y      = s_axis_tdata[2*POS_W-1:POS_W];
        in_item.hit_length = s_axis_tdata[IN_W-1:2*POS_W];
    end

    assign s_axis_tready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_pop && (cnt_reg != '0);
    assign q_valid       = (cnt_reg != '0);
    assign q_item        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/core/sdp_back.sv */
// chaining engine: walks stored hits, scores them, reports the result and stores the new hit unless full
module sdp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  sdp_pkg::hit_t               q_item,
    output logic                        ram_we,
    output logic [sdp_pkg::IDX_W-1:0]   ram_waddr,
    output sdp_pkg::ram_word_t          ram_wdata,
    output logic                        ram_re,
    output logic [sdp_pkg::IDX_W-1:0]   ram_raddr,
    input  sdp_pkg::ram_word_t          ram_rdata,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sdp_pkg::result_t            res
);
    import sdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    hit_t                      item_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          n_reg;
    logic [CNT_W-1:0]          k_reg, k_next;
    logic [CNT_W-1:0]          k_dec;

    logic                      p1_valid_reg;
    logic [IDX_W-1:0]          p1_idx_reg;
    logic                      p2_valid_reg;
    logic [IDX_W-1:0]          p2_idx_reg;
    logic signed [DIFF_W-1:0]  dy_reg, dx_reg;
    logic signed [SCORE_W-1:0] p2_score_reg;
    logic                      p3_valid_reg;
    logic [IDX_W-1:0]          p3_idx_reg;
    logic signed [DIFF_W-1:0]  m_reg;
    logic signed [DIFF_W:0]    g_reg;
    logic signed [SCORE_W-1:0] p3_score_reg;
    logic                      p4_valid_reg;
    logic [IDX_W-1:0]          p4_idx_reg;
    logic signed [SCORE_W-1:0] cand_reg;

    logic signed [SCORE_W-1:0] best_reg;
    logic [IDX_W-1:0]          pred_reg;
    logic                      found_reg;

    logic                      out_valid_reg;
    result_t                   out_reg;

    logic signed [DIFF_W-1:0]  dy_next, dx_next, len_ext, m_next, min_dxy;
    logic signed [DIFF_W:0]    d_next, g_next;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SCORE_W-1:0] cand_next;
    logic                      start_item;
    logic                      walk_done;
    logic                      full;
    logic                      out_load;

    assign start_item      = (state_reg == ST_IDLE) && q_valid;
    assign q_pop           = start_item;
    assign k_dec           = k_reg - CNT_W'(1);
    assign ram_re          = (state_reg == ST_WALK) && (k_reg != '0);
    assign ram_raddr       = k_dec[IDX_W-1:0];
    assign walk_done       = (k_reg == '0) && !p1_valid_reg && !p2_valid_reg
                             && !p3_valid_reg && !p4_valid_reg;
    assign full            = (n_reg == CNT_W'(MAX_HITS));
    assign out_load        = (state_reg == ST_FINISH) && (!out_valid_reg || res_ready);

    assign ram_we          = out_load && !full;
    assign ram_waddr       = n_reg[IDX_W-1:0];
    assign ram_wdata.score = best_reg;
    assign ram_wdata.y     = item_reg.hit_y;
    assign ram_wdata.x     = item_reg.hit_x;

    assign res_valid       = out_valid_reg;
    assign res             = out_reg;

    // candidate arithmetic, one step per stage
    always_comb
    begin
        dy_next  = $signed({1'b0, item_reg.hit_y}) - $signed({1'b0, ram_rdata.y});
        dx_next  = $signed({1'b0, item_reg.hit_x}) - $signed({1'b0, ram_rdata.x});
        len_ext  = $signed({{(DIFF_W - LEN_W){1'b0}}, item_reg.hit_length});
        min_dxy  = (dy_reg < dx_reg) ? dy_reg : dx_reg;
        m_next   = (min_dxy < len_ext) ? min_dxy : len_ext;
        d_next   = $signed({dy_reg[DIFF_W-1], dy_reg}) - $signed({dx_reg[DIFF_W-1], dx_reg});
        g_next   = d_next[DIFF_W] ? -d_next : d_next;
        sum_next = SUM_W'(p3_score_reg) + SUM_W'(m_reg) - SUM_W'(g_reg);
        if (!sum_next[SUM_W-1] && (sum_next[SUM_W-2:SCORE_W-1] != '0))
        begin
            cand_next = {1'b0, {(SCORE_W-1){1'b1}}};
        end
        else if (sum_next[SUM_W-1] && (sum_next[SUM_W-2:SCORE_W-1] != '1))
        begin
            cand_next = {1'b1, {(SCORE_W-1){1'b0}}};
        end
        else
        begin
            cand_next = sum_next[SCORE_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_item)
                begin
                    count_next = q_item.start_set ? '0 : count_reg;
                    k_next     = count_next;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (k_reg != '0)
                begin
                    k_next = k_dec;
                end
                else if (walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    if (!full)
                    begin
                        count_next = n_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            p1_valid_reg <= ram_re;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_item)
        begin
            item_reg  <= q_item;
            n_reg     <= count_next;
            best_reg  <= $signed({{(SCORE_W - LEN_W){1'b0}}, q_item.hit_length});
            pred_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (p4_valid_reg && (cand_reg > best_reg))
        begin
            best_reg  <= cand_reg;
            pred_reg  <= p4_idx_reg;
            found_reg <= 1'b1;
        end
        p1_idx_reg   <= ram_raddr;
        p2_idx_reg   <= p1_idx_reg;
        dy_reg       <= dy_next;
        dx_reg       <= dx_next;
        p2_score_reg <= $signed(ram_rdata.score);
        p3_idx_reg   <= p2_idx_reg;
        m_reg        <= m_next;
        g_reg        <= g_next;
        p3_score_reg <= p2_score_reg;
        p4_idx_reg   <= p3_idx_reg;
        cand_reg     <= cand_next;
        if (out_load)
        begin
            out_reg.chain_score <= best_reg;
            out_reg.pred_index  <= found_reg ? out_idx(pred_reg) : '0;
            out_reg.has_pred    <= found_reg;
            out_reg.hit_index   <= full ? '0 : out_idx(n_reg[IDX_W-1:0]);
            out_reg.overflow    <= full;
        end
    end

endmodule

/* rtl/core/seed_hit_chaining_dp.sv */
// seed hit chaining top level: queue, chaining engine and hit memory
// each result follows its hit after a walk over every stored hit in the set
// a stalled result register holds the engine in ST_FINISH until the result is taken
// the engine takes a new hit only after the last one's walk and result load are done
// the engine reads one stored hit per cycle through a four stage scoring pipeline
// reset clears the hit count, queue and handshake state; the hit memory is not cleared
module seed_hit_chaining_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [sdp_pkg::IN_W-1:0]  s_axis_tdata,  // hit_x, hit_y, hit_length
    input  logic                      s_axis_tuser,  // start_set
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [sdp_pkg::OUT_W-1:0] m_axis_tdata   // chain_score, pred_index, has_pred,
                                                     // hit_index, overflow
);
    import sdp_pkg::*;

    logic             q_valid;
    logic             q_pop;
    hit_t             q_item;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    ram_word_t        ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    ram_word_t        ram_rdata;
    result_t          res;

    sdp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item)
    );

    sdp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    sdp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_HITS)
    ) u_hit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tdata = {
        {(OUT_W - $bits(result_t)){1'b0}},
        res.overflow,
        res.hit_index,
        res.has_pred,
        res.pred_index,
        res.chain_score
    };

endmodule
